/* sv/drw_pkg.sv */
//==============================================================================
// drw_pkg
// Shared widths, reset values and control bundles for the draw block.
//==============================================================================
`default_nettype none

package drw_pkg;

    // Field widths
    localparam int RV_W    = 31;   // random value
    localparam int CNT_W   = 7;    // deck size, counts, ranks
    localparam int IDX_W   = 6;    // entry index output
    localparam int BITS_W  = 5;    // bit counter of the serial modulo

    // Deck size after reset
    localparam logic [CNT_W-1:0] DECK_RESET = 7'd60;

    // Draw counter saturation value
    localparam logic [CNT_W-1:0] DRAWS_MAX = 7'd127;

    // Mark ring control
    typedef struct packed {
        logic rotate;   // shift the ring by one entry
        logic mark;     // write 1 into the entry leaving the head
    } ring_ctl_t;

    // Serial modulo control
    typedef struct packed {
        logic load;     // capture a new dividend
        logic start;    // run with the current divisor
    } mod_ctl_t;

endpackage

`default_nettype wire

/* sv/drw_ring.sv */
//==============================================================================
// drw_ring
// Circular shift register of drawn marks, one entry presented per cycle while rotate is set.
//==============================================================================
`default_nettype none

module drw_ring
    import drw_pkg::*;
#(
    parameter int DEPTH = 64
)(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ring_ctl_t ctl,
    output logic           head
);

    logic [DEPTH-1:0] marks_reg;
    logic [DEPTH-1:0] marks_next;

    // Head entry leaves at bit 0 and re-enters at the top
    always_comb
    begin
        marks_next = marks_reg;
        if (ctl.rotate)
        begin
            marks_next = {(ctl.mark | marks_reg[0]), marks_reg[DEPTH-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    assign head = marks_reg[0];

endmodule

`default_nettype wire

/* sv/drw_modser.sv */
//==============================================================================
// drw_modser
// Bit-serial restoring modulo: one dividend bit per cycle while busy, MSB first.
//==============================================================================
`default_nettype none

module drw_modser
    import drw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mod_ctl_t         ctl,
    input  wire logic [RV_W-1:0]  dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [CNT_W-1:0]      rem
);

    localparam logic [BITS_W-1:0] LAST_BIT = BITS_W'(RV_W - 1);

    logic [RV_W-1:0]   dvd_reg,  dvd_next;
    logic [CNT_W-1:0]  rem_reg,  rem_next;
    logic [BITS_W-1:0] cnt_reg,  cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    // One shift-and-subtract step per cycle while busy
    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[RV_W-1]};
        if (trial >= {1'b0, divisor})
        begin
            trial = trial - {1'b0, divisor};
        end
        if (ctl.load)
        begin
            dvd_next = dividend;
        end
        if (ctl.start)
        begin
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = trial[CNT_W-1:0];
            dvd_next = {dvd_reg[RV_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_BIT)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

/* sv/draw_without_replacement.sv */
//==============================================================================
// draw_without_replacement
// Draws deck entries without replacement from a bitmap of drawn marks.
//==============================================================================
// Usage:
//   Input channel draw_valid/draw_stall carries random_value. The result
//   channel result_valid/result_stall returns entry_index, draw_number,
//   deck_emptied and exhausted. cfg_write/cfg_data set the deck size; write
//   it only while no draw is in flight.
// Sequence: a count pass over the min(MAX_ENTRIES, 127) mark entries, the
//   serial modulo (a start step, a step for each of the 31 dividend bits,
//   done), a select pass and the result load. An empty deck skips the
//   modulo and select passes. One item is in work at a time; the next is
//   taken once the result is registered.
// Reset clears all drawn marks and the draw count and sets the deck size
//   to 60. A stalled result holds; the block then waits before finishing
//   the following item.
//==============================================================================
`default_nettype none

module draw_without_replacement
    import drw_pkg::*;
#(
    parameter int MAX_ENTRIES = 64
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             draw_valid,
    output logic                  draw_stall,
    input  wire logic [RV_W-1:0]  random_value,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output logic [IDX_W-1:0]      entry_index,
    output logic [CNT_W-1:0]      draw_number,
    output logic                  deck_emptied,
    output logic                  exhausted
);

    // Only entries below the 7-bit deck size can ever be in play
    localparam int DEPTH = (MAX_ENTRIES < 128) ? MAX_ENTRIES : 127;
    localparam int IW    = $clog2(DEPTH);
    localparam logic [IW-1:0]    IDX_LAST = IW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_COUNT  = 3'd1;
    localparam logic [2:0] S_DIVIDE = 3'd2;
    localparam logic [2:0] S_SELECT = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]       state_reg,   state_next;
    logic [CNT_W-1:0] deck_reg,    deck_next;
    logic [CNT_W-1:0] draws_reg,   draws_next;
    logic [IW-1:0]    idx_reg,     idx_next;
    logic [CNT_W-1:0] undrawn_reg, undrawn_next;
    logic [CNT_W-1:0] seen_reg,    seen_next;
    logic             found_reg,   found_next;
    logic [IW-1:0]    pick_reg,    pick_next;
    logic             oval_reg,    oval_next;
    logic [IDX_W-1:0] oidx_reg,    oidx_next;
    logic [CNT_W-1:0] onum_reg,    onum_next;
    logic             oemp_reg,    oemp_next;
    logic             oexh_reg,    oexh_next;

    logic [CNT_W-1:0] size;
    logic             head;
    logic             open_entry;
    logic             out_free;
    logic             mod_done;
    logic [CNT_W-1:0] rank;
    logic [CNT_W-1:0] draws_inc;
    ring_ctl_t        ring_ctl;
    mod_ctl_t         mod_ctl;

    // Deck size in use, clamped to the ring depth
    assign size = (deck_reg > DEPTH_C) ? DEPTH_C : deck_reg;

    // Entry at the ring head is undrawn and inside the deck
    assign open_entry = !head && (CNT_W'(idx_reg) < size);

    assign out_free   = !oval_reg || !result_stall;
    assign draw_stall = (state_reg != S_IDLE);
    assign draws_inc  = (draws_reg == DRAWS_MAX) ? draws_reg : draws_reg + 1'b1;

    drw_ring #(
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ring_ctl),
        .head  (head)
    );

    drw_modser u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (mod_ctl),
        .dividend (random_value),
        .divisor  (undrawn_reg),
        .done     (mod_done),
        .rem      (rank)
    );

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        deck_next    = cfg_write ? cfg_data : deck_reg;
        draws_next   = draws_reg;
        idx_next     = idx_reg;
        undrawn_next = undrawn_reg;
        seen_next    = seen_reg;
        found_next   = found_reg;
        pick_next    = pick_reg;
        oval_next    = oval_reg && result_stall;
        oidx_next    = oidx_reg;
        onum_next    = onum_reg;
        oemp_next    = oemp_reg;
        oexh_next    = oexh_reg;
        ring_ctl     = '0;
        mod_ctl      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (draw_valid)
                begin
                    mod_ctl.load = 1'b1;
                    idx_next     = '0;
                    undrawn_next = '0;
                    state_next   = S_COUNT;
                end
            end
            S_COUNT:
            begin
                ring_ctl.rotate = 1'b1;
                idx_next        = idx_reg + 1'b1;
                if (open_entry)
                begin
                    undrawn_next = undrawn_reg + 1'b1;
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next = '0;
                    if (undrawn_next == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE:
            begin
                mod_ctl.start = (idx_reg == '0);
                idx_next      = '1;
                if (mod_done)
                begin
                    idx_next   = '0;
                    seen_next  = '0;
                    found_next = 1'b0;
                    state_next = S_SELECT;
                end
            end
            S_SELECT:
            begin
                ring_ctl.rotate = 1'b1;
                idx_next        = idx_reg + 1'b1;
                if (open_entry && !found_reg)
                begin
                    if (seen_reg == rank)
                    begin
                        ring_ctl.mark = 1'b1;
                        found_next    = 1'b1;
                        pick_next     = idx_reg;
                    end
                    else
                    begin
                        seen_next = seen_reg + 1'b1;
                    end
                end
                if (idx_reg == IDX_LAST)
                begin
                    idx_next   = '0;
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    oval_next = 1'b1;
                    if (undrawn_reg == '0)
                    begin
                        oidx_next = '0;
                        onum_next = '0;
                        oemp_next = 1'b0;
                        oexh_next = 1'b1;
                    end
                    else
                    begin
                        draws_next = draws_inc;
                        oidx_next  = IDX_W'(pick_reg);
                        onum_next  = draws_inc;
                        oemp_next  = (undrawn_reg == CNT_W'(1));
                        oexh_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            deck_reg  <= DECK_RESET;
            draws_reg <= '0;
            oval_reg  <= 1'b0;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            deck_reg  <= deck_next;
            draws_reg <= draws_next;
            oval_reg  <= oval_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        undrawn_reg <= undrawn_next;
        seen_reg    <= seen_next;
        pick_reg    <= pick_next;
        oidx_reg    <= oidx_next;
        onum_reg    <= onum_next;
        oemp_reg    <= oemp_next;
        oexh_reg    <= oexh_next;
    end

    assign result_valid = oval_reg;
    assign entry_index  = oidx_reg;
    assign draw_number  = onum_reg;
    assign deck_emptied = oemp_reg;
    assign exhausted    = oexh_reg;

endmodule

`default_nettype wire
